FILE: rtl/nfb_pkg.sv
// Shared types and command codes for the nibble framebuffer draw engine.
`timescale 1ns / 1ps

package nfb_pkg;

	typedef enum logic [2:0] {
		CMD_PIXEL  = 3'd0,
		CMD_HLINE  = 3'd1,
		CMD_VLINE  = 3'd2,
		CMD_RECT   = 3'd3,
		CMD_FILL   = 3'd4,
		CMD_CIRCLE = 3'd5,
		CMD_READ   = 3'd6
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic              rd;
		logic [7:0]        bx;
		logic [7:0]        by;
		logic signed [8:0] ox;
		logic signed [8:0] oy;
		logic [3:0]        shade;
	} pt_t;

	typedef struct packed {
		logic       wr;
		logic       rd;
		logic       lo;
		logic       in_range;
		logic [3:0] shade;
	} mem_ctl_t;

	typedef struct packed {
		logic       valid;
		logic       lo;
		logic       in_range;
		logic [7:0] data;
	} rsp_t;

endpackage

FILE: rtl/nfb_sequencer.sv
// Command sequencer that steps through spans and circle octants, at most one point per cycle.
`timescale 1ns / 1ps

module nfb_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    cmd,
	input  logic [7:0]    x_start,
	input  logic [7:0]    y_start,
	input  logic [7:0]    x_end,
	input  logic [7:0]    y_end,
	input  logic [7:0]    radius,
	input  logic [3:0]    shade,
	output logic          busy,
	output nfb_pkg::pt_t  pt
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ONE  = 4'b0010,
		ST_SPAN = 4'b0100,
		ST_CIRC = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		CP_INIT = 3'b001,
		CP_STEP = 3'b010,
		CP_EMIT = 3'b100
	} circ_ph_t;

	localparam logic [1:0] SEG_LEFT   = 2'd0;
	localparam logic [1:0] SEG_RIGHT  = 2'd1;
	localparam logic [1:0] SEG_TOP    = 2'd2;
	localparam logic [1:0] SEG_BOTTOM = 2'd3;

	state_t             state_q;
	circ_ph_t           cph_q;
	nfb_pkg::cmd_t      cmd_q;
	logic [7:0]         xs_q, ys_q, xe_q, ye_q, r_q;
	logic [3:0]         shade_q;
	logic [1:0]         seg_q;
	logic [7:0]         a_q, col_q;
	logic [2:0]         k_q;
	logic [7:0]         cxp_q, cyp_q;
	logic signed [11:0] f_q;

	logic               vert, v_empty, h_empty, seg_empty, seg_done, fill_more;
	logic [7:0]         span_end, fixed;
	logic [1:0]         last_seg, seg_nx;
	logic signed [11:0] x2, y2, f_nx;
	logic signed [8:0]  px, py, pr, oa, ob;

	assign busy = !state_q[0];

	assign vert      = !seg_q[1];
	assign v_empty   = ys_q > ye_q;
	assign h_empty   = xs_q > xe_q;
	assign span_end  = vert ? ye_q : xe_q;
	assign seg_empty = (cmd_q == nfb_pkg::CMD_FILL) ? (v_empty || h_empty)
	                                                 : (vert ? v_empty : h_empty);
	assign seg_done  = seg_empty || (a_q == span_end);
	assign fill_more = (cmd_q == nfb_pkg::CMD_FILL) && !h_empty && (col_q != xe_q);
	assign seg_nx    = seg_q + 2'd1;

	always_comb begin
		unique case (seg_q)
			SEG_LEFT:   fixed = (cmd_q == nfb_pkg::CMD_FILL) ? col_q : xs_q;
			SEG_RIGHT:  fixed = xe_q;
			SEG_TOP:    fixed = ys_q;
			SEG_BOTTOM: fixed = ye_q;
			default:    fixed = xs_q;
		endcase
	end

	always_comb begin
		unique case (cmd_q)
			nfb_pkg::CMD_HLINE: last_seg = SEG_TOP;
			nfb_pkg::CMD_VLINE: last_seg = SEG_LEFT;
			nfb_pkg::CMD_FILL:  last_seg = SEG_LEFT;
			default:            last_seg = SEG_BOTTOM;
		endcase
	end

	assign x2   = signed'({3'b000, cxp_q, 1'b0});
	assign y2   = signed'({3'b000, cyp_q, 1'b0});
	assign f_nx = f_q + x2 + 12'sd3 + (f_q[11] ? 12'sd0 : (12'sd2 - y2));

	assign px = signed'({1'b0, cxp_q});
	assign py = signed'({1'b0, cyp_q});
	assign pr = signed'({1'b0, r_q});
	assign oa = k_q[2] ? py : px;
	assign ob = k_q[2] ? px : py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cph_q   <= CP_INIT;
			cmd_q   <= nfb_pkg::CMD_PIXEL;
			xs_q    <= '0;
			ys_q    <= '0;
			xe_q    <= '0;
			ye_q    <= '0;
			r_q     <= '0;
			shade_q <= '0;
			seg_q   <= SEG_LEFT;
			a_q     <= '0;
			col_q   <= '0;
			k_q     <= '0;
			cxp_q   <= '0;
			cyp_q   <= '0;
			f_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= nfb_pkg::cmd_t'(cmd);
						xs_q    <= x_start;
						ys_q    <= y_start;
						xe_q    <= x_end;
						ye_q    <= y_end;
						r_q     <= radius;
						shade_q <= shade;
						seg_q   <= SEG_LEFT;
						a_q     <= y_start;
						col_q   <= x_start;
						k_q     <= '0;
						cph_q   <= CP_INIT;
						cxp_q   <= '0;
						cyp_q   <= radius;
						f_q     <= 12'sd1 - signed'({4'b0000, radius});
						unique case (cmd)
							nfb_pkg::CMD_PIXEL, nfb_pkg::CMD_READ: state_q <= ST_ONE;
							nfb_pkg::CMD_HLINE: begin
								seg_q   <= SEG_TOP;
								a_q     <= x_start;
								state_q <= ST_SPAN;
							end
							nfb_pkg::CMD_VLINE, nfb_pkg::CMD_RECT,
							nfb_pkg::CMD_FILL: state_q <= ST_SPAN;
							nfb_pkg::CMD_CIRCLE: state_q <= ST_CIRC;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ONE: state_q <= ST_IDLE;
				ST_SPAN: begin
					priority if (!seg_done) begin
						a_q <= a_q + 8'd1;
					end else if (fill_more) begin
						col_q <= col_q + 8'd1;
						a_q   <= ys_q;
					end else if (seg_q == last_seg) begin
						state_q <= ST_IDLE;
					end else begin
						seg_q <= seg_nx;
						a_q   <= seg_nx[1] ? xs_q : ys_q;
					end
				end
				ST_CIRC: begin
					unique case (cph_q)
						CP_INIT: begin
							k_q <= k_q + 3'd1;
							if (k_q[1:0] == 2'd3) begin
								k_q   <= '0;
								cph_q <= CP_STEP;
							end
						end
						CP_STEP: begin
							if (cxp_q < cyp_q) begin
								f_q   <= f_nx;
								cxp_q <= cxp_q + 8'd1;
								if (!f_q[11]) begin
									cyp_q <= cyp_q - 8'd1;
								end
								k_q   <= '0;
								cph_q <= CP_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						CP_EMIT: begin
							k_q <= k_q + 3'd1;
							if (k_q == 3'd7) begin
								cph_q <= CP_STEP;
							end
						end
						default: cph_q <= CP_INIT;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		pt       = '0;
		pt.shade = shade_q;
		pt.rd    = (cmd_q == nfb_pkg::CMD_READ);
		unique case (state_q)
			ST_ONE: begin
				pt.valid = 1'b1;
				pt.bx    = xs_q;
				pt.by    = ys_q;
			end
			ST_SPAN: begin
				pt.valid = !seg_empty;
				pt.bx    = vert ? fixed : a_q;
				pt.by    = vert ? a_q : fixed;
			end
			ST_CIRC: begin
				pt.bx = xs_q;
				pt.by = ys_q;
				unique case (cph_q)
					CP_INIT: begin
						pt.valid = 1'b1;
						pt.ox    = k_q[1] ? (k_q[0] ? -pr : pr) : 9'sd0;
						pt.oy    = k_q[1] ? 9'sd0 : (k_q[0] ? -pr : pr);
					end
					CP_EMIT: begin
						pt.valid = 1'b1;
						pt.ox    = k_q[0] ? -oa : oa;
						pt.oy    = k_q[1] ? -ob : ob;
					end
					default: pt.valid = 1'b0;
				endcase
			end
			default: pt.valid = 1'b0;
		endcase
	end

endmodule

FILE: rtl/nfb_pixel_unit.sv
// Shared pixel unit: coordinate add, clipping and byte address generation over two stages.
`timescale 1ns / 1ps

module nfb_pixel_unit #(
	parameter int FRAME_WIDTH  = 256,
	parameter int FRAME_HEIGHT = 64,
	parameter int PIX_W        = 14,
	parameter int ADDR_W       = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nfb_pkg::pt_t           pt,
	output nfb_pkg::mem_ctl_t      ctl,
	output logic [ADDR_W-1:0]      addr
);

	logic               valid_s1, rd_s1;
	logic [3:0]         shade_s1;
	logic signed [9:0]  x_s1, y_s1;
	logic               x_in, y_in, in_frame;
	logic [16:0]        prod;
	logic [PIX_W-1:0]   pix;

	nfb_pkg::mem_ctl_t  ctl_s2;
	logic [ADDR_W-1:0]  addr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pt.valid;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1    <= pt.rd;
		shade_s1 <= pt.shade;
		x_s1     <= signed'({2'b00, pt.bx}) + {pt.ox[8], pt.ox};
		y_s1     <= signed'({2'b00, pt.by}) + {pt.oy[8], pt.oy};
	end

	assign x_in     = !x_s1[9] && (x_s1[8:0] < 9'(FRAME_WIDTH));
	assign y_in     = !y_s1[9] && (y_s1[8:0] < 9'(FRAME_HEIGHT));
	assign in_frame = x_in && y_in;
	assign prod     = 17'(y_s1[7:0]) * 17'(FRAME_WIDTH) + 17'(x_s1[7:0]);
	assign pix      = PIX_W'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			addr_s2 <= '0;
		end else begin
			ctl_s2.wr       <= valid_s1 && !rd_s1 && in_frame;
			ctl_s2.rd       <= valid_s1 && rd_s1;
			ctl_s2.lo       <= pix[0];
			ctl_s2.in_range <= in_frame;
			ctl_s2.shade    <= shade_s1;
			addr_s2         <= ADDR_W'(pix >> 1);
		end
	end

	assign ctl  = ctl_s2;
	assign addr = addr_s2;

endmodule

FILE: rtl/nfb_frame_mem.sv
// Byte-wide frame memory with per-nibble writes and a registered read port.
`timescale 1ns / 1ps

module nfb_frame_mem #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nfb_pkg::mem_ctl_t   ctl,
	input  logic [ADDR_W-1:0]   addr,
	output nfb_pkg::rsp_t       rsp
);

	logic [7:0] mem [DEPTH];
	logic [7:0] data_s3;
	logic       valid_s3, lo_s3, in_s3;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			if (ctl.lo) begin
				mem[addr][3:0] <= ctl.shade;
			end else begin
				mem[addr][7:4] <= ctl.shade;
			end
		end
		if (ctl.rd && ctl.in_range) begin
			data_s3 <= mem[addr];
		end
		lo_s3 <= ctl.lo;
		in_s3 <= ctl.in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctl.rd;
		end
	end

	assign rsp = {valid_s3, lo_s3, in_s3, data_s3};

endmodule

FILE: rtl/nibble_framebuffer_draw_engine_top.sv
// Top level of the nibble framebuffer draw engine.
//
// Channel   Direction  Handshake              Signals
// command   in         start high, busy low   cmd, x_start, y_start, x_end, y_end, radius, shade
// readback  out        done for one cycle     pixel_value, pixel_in_range
//
// The sequencer emits at most one pixel per cycle into a shared add, clip and address unit.
// Busy stays high while the points are emitted: the point of a pixel or read, each point of
// each line or rectangle edge (an empty span emits none), each pixel of a filled rectangle,
// and for a circle four axis points, then eight octant points per midpoint loop step.
// Done follows a read through the pixel unit stages, the memory read register and a done register.
// Reset clears control state only; the frame memory holds no defined contents.
// The receiver cannot stall, so every result transfer completes in its single cycle.
`timescale 1ns / 1ps

module nibble_framebuffer_draw_engine_top #(
	parameter int FRAME_WIDTH  = 256,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] cmd,
	input  logic [7:0] x_start,
	input  logic [7:0] y_start,
	input  logic [7:0] x_end,
	input  logic [7:0] y_end,
	input  logic [7:0] radius,
	input  logic [3:0] shade,
	output logic       done,
	output logic [3:0] pixel_value,
	output logic       pixel_in_range
);

	localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int BYTES  = (PIXELS + 1) / 2;
	localparam int PIX_W  = $clog2(PIXELS);
	localparam int ADDR_W = (BYTES > 1) ? $clog2(BYTES) : 1;

	nfb_pkg::pt_t       pt;
	nfb_pkg::mem_ctl_t  ctl;
	nfb_pkg::rsp_t      rsp;
	logic [ADDR_W-1:0]  addr;

	logic               done_q;
	logic [3:0]         pixel_value_q;
	logic               pixel_in_range_q;

	nfb_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.radius  (radius),
		.shade   (shade),
		.busy    (busy),
		.pt      (pt)
	);

	nfb_pixel_unit #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.PIX_W        (PIX_W),
		.ADDR_W       (ADDR_W)
	) u_pix (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt),
		.ctl    (ctl),
		.addr   (addr)
	);

	nfb_frame_mem #(
		.DEPTH  (BYTES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.addr   (addr),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel_in_range_q <= rsp.in_range;
		pixel_value_q    <= rsp.in_range ? (rsp.lo ? rsp.data[3:0] : rsp.data[7:4]) : 4'h0;
	end

	assign done           = done_q;
	assign pixel_value    = pixel_value_q;
	assign pixel_in_range = pixel_in_range_q;

endmodule

FILE: bench/nibble_framebuffer_draw_engine_top_tb.sv
// Self-checking testbench for the nibble framebuffer draw engine, with a shadow frame predictor.
`timescale 1ns / 1ps

module nibble_framebuffer_draw_engine_top_tb;

	localparam int FW = 256;
	localparam int FH = 64;
	localparam int STORE_BYTES = (FW * FH + 1) / 2;
	localparam int NUM_RANDOM = 1000;
	localparam int MAX_BIG_FILLS = 3;
	localparam logic [2:0] CMD_NONE = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] xs;
		logic [7:0] ys;
		logic [7:0] xe;
		logic [7:0] ye;
		logic [7:0] rad;
		logic [3:0] shade;
		logic       pinned;
		logic [3:0] pin_value;
		logic       pin_in;
	} draw_item_t;

	typedef struct packed {
		logic [3:0] value;
		logic       in_range;
	} readback_t;

	// Rows with pinned set carry a readback value that follows directly from the rows above.
	localparam draw_item_t DIRECTED_ROWS [26] = '{
		'{nfb_pkg::CMD_READ, 8'd0, 8'd64, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd0, 1'b0},
		'{nfb_pkg::CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 4'd10, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd10, 1'b1},
		'{nfb_pkg::CMD_READ, 8'd255, 8'd63, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd10, 1'b1},
		'{nfb_pkg::CMD_PIXEL, 8'd255, 8'd63, 8'd0, 8'd0, 8'd0, 4'd15, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_READ, 8'd255, 8'd63, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd15, 1'b1},
		'{nfb_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd0, 1'b1},
		'{nfb_pkg::CMD_READ, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd10, 1'b1},
		'{nfb_pkg::CMD_PIXEL, 8'd10, 8'd200, 8'd0, 8'd0, 8'd0, 4'd5, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_READ, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd0, 1'b0},
		'{nfb_pkg::CMD_HLINE, 8'd250, 8'd5, 8'd255, 8'd0, 8'd0, 4'd3, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_HLINE, 8'd20, 8'd6, 8'd10, 8'd0, 8'd0, 4'd4, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_VLINE, 8'd7, 8'd60, 8'd0, 8'd255, 8'd0, 4'd9, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_VLINE, 8'd8, 8'd10, 8'd0, 8'd9, 8'd0, 4'd1, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_RECT, 8'd10, 8'd10, 8'd20, 8'd20, 8'd0, 4'd6, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_RECT, 8'd40, 8'd10, 8'd30, 8'd20, 8'd0, 4'd2, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_RECT, 8'd50, 8'd30, 8'd60, 8'd20, 8'd0, 4'd13, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_FILL, 8'd100, 8'd40, 8'd103, 8'd42, 8'd0, 4'd12, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_FILL, 8'd5, 8'd5, 8'd4, 8'd9, 8'd0, 4'd3, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_CIRCLE, 8'd128, 8'd32, 8'd0, 8'd0, 8'd0, 4'd1, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_READ, 8'd128, 8'd32, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 4'd1, 1'b1},
		'{nfb_pkg::CMD_CIRCLE, 8'd2, 8'd2, 8'd0, 8'd0, 8'd20, 4'd7, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_CIRCLE, 8'd200, 8'd40, 8'd0, 8'd0, 8'd255, 4'd14, 1'b0, 4'd0, 1'b0},
		'{CMD_NONE, 8'd77, 8'd33, 8'd200, 8'd250, 8'd99, 4'd8, 1'b0, 4'd0, 1'b0},
		'{nfb_pkg::CMD_READ, 8'd2, 8'd22, 8'd0, 8'd0, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] cmd;
	logic [7:0] x_start;
	logic [7:0] y_start;
	logic [7:0] x_end;
	logic [7:0] y_end;
	logic [7:0] radius;
	logic [3:0] shade;
	logic       done;
	logic [3:0] pixel_value;
	logic       pixel_in_range;

	logic [7:0] frame_shadow [0:STORE_BYTES-1];
	readback_t  pending_reads [$];
	logic       pin_valid;
	logic [3:0] pin_value;
	logic       pin_in;

	int errors = 0;
	int n_draws = 0;
	int n_reads = 0;
	int n_unused = 0;
	int n_checked = 0;
	int big_fills = 0;
	int burst_left = 0;
	logic [7:0] mark_x = 8'd0;
	logic [7:0] mark_y = 8'd0;

	nibble_framebuffer_draw_engine_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.radius(radius),
		.shade(shade),
		.done(done),
		.pixel_value(pixel_value),
		.pixel_in_range(pixel_in_range)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bit on_frame(int x, int y);
		return x >= 0 && x < FW && y >= 0 && y < FH;
	endfunction

	task automatic plot(int x, int y, logic [3:0] s);
		int idx;
		if (on_frame(x, y)) begin
			idx = y * FW + x;
			if (idx[0])
				frame_shadow[idx >> 1][3:0] = s;
			else
				frame_shadow[idx >> 1][7:4] = s;
		end
	endtask

	function automatic logic [3:0] peek(int x, int y);
		int idx;
		if (!on_frame(x, y))
			return 4'd0;
		idx = y * FW + x;
		return idx[0] ? frame_shadow[idx >> 1][3:0] : frame_shadow[idx >> 1][7:4];
	endfunction

	task automatic hspan(int y, int x0, int x1, logic [3:0] s);
		for (int i = x0; i <= x1; i++)
			plot(i, y, s);
	endtask

	task automatic vspan(int x, int y0, int y1, logic [3:0] s);
		for (int i = y0; i <= y1; i++)
			plot(x, i, s);
	endtask

	task automatic ring(int cx, int cy, int r, logic [3:0] s);
		int f;
		int ddx;
		int ddy;
		int x;
		int y;
		f = 1 - r;
		ddx = 1;
		ddy = -2 * r;
		x = 0;
		y = r;
		plot(cx, cy + r, s);
		plot(cx, cy - r, s);
		plot(cx + r, cy, s);
		plot(cx - r, cy, s);
		while (x < y) begin
			if (f >= 0) begin
				y--;
				ddy += 2;
				f += ddy;
			end
			x++;
			ddx += 2;
			f += ddx;
			plot(cx + x, cy + y, s);
			plot(cx - x, cy + y, s);
			plot(cx + x, cy - y, s);
			plot(cx - x, cy - y, s);
			plot(cx + y, cy + x, s);
			plot(cx - y, cy + x, s);
			plot(cx + y, cy - x, s);
			plot(cx - y, cy - x, s);
		end
	endtask

	task automatic render_command(input logic [2:0] op, input int xs, input int ys,
			input int xe, input int ye, input int r, input logic [3:0] s,
			output bit has_read, output readback_t rb);
		has_read = 1'b0;
		rb = '0;
		unique case (op)
			nfb_pkg::CMD_PIXEL: plot(xs, ys, s);
			nfb_pkg::CMD_HLINE: hspan(ys, xs, xe, s);
			nfb_pkg::CMD_VLINE: vspan(xs, ys, ye, s);
			nfb_pkg::CMD_RECT: begin
				vspan(xs, ys, ye, s);
				vspan(xe, ys, ye, s);
				hspan(ys, xs, xe, s);
				hspan(ye, xs, xe, s);
			end
			nfb_pkg::CMD_FILL: begin
				for (int i = xs; i <= xe; i++)
					vspan(i, ys, ye, s);
			end
			nfb_pkg::CMD_CIRCLE: ring(xs, ys, r, s);
			nfb_pkg::CMD_READ: begin
				has_read = 1'b1;
				rb.value = peek(xs, ys);
				rb.in_range = on_frame(xs, ys);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		readback_t want;
		readback_t predicted;
		bit has_read;
		if (arst_n) begin
			if (done) begin
				if (pending_reads.size() == 0) begin
					$error("Readback transfer with no read outstanding: value %0d, in_range %0b",
						pixel_value, pixel_in_range);
					errors++;
				end else begin
					want = pending_reads.pop_front();
					n_checked++;
					if (pixel_value !== want.value) begin
						$error("pixel_value: expected %0d, got %0d", want.value, pixel_value);
						errors++;
					end
					if (pixel_in_range !== want.in_range) begin
						$error("pixel_in_range: expected %0b, got %0b", want.in_range,
							pixel_in_range);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				render_command(cmd, int'(x_start), int'(y_start), int'(x_end), int'(y_end),
					int'(radius), shade, has_read, predicted);
				if (has_read) begin
					n_reads++;
					if (pin_valid)
						pending_reads.push_back({pin_value, pin_in});
					else
						pending_reads.push_back(predicted);
				end else if (cmd == CMD_NONE) begin
					n_unused++;
				end else begin
					n_draws++;
				end
			end
		end
	end

	function automatic logic [7:0] clamp8(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic logic [7:0] span_end(logic [7:0] from, int reach, bit wild);
		int k;
		k = $urandom_range(0, 15);
		if (wild && k == 0)
			return 8'($urandom_range(0, 255));
		if (k == 1)
			return clamp8(int'(from) - 1 - int'($urandom_range(0, 7)));
		return clamp8(int'(from) + int'($urandom_range(0, reach)));
	endfunction

	task automatic pick_random(output draw_item_t it);
		int sel;
		it = '0;
		it.xs = 8'($urandom_range(0, 255));
		it.ys = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
		                                    : 8'($urandom_range(0, 63));
		it.xe = 8'($urandom_range(0, 255));
		it.ye = 8'($urandom_range(0, 255));
		it.rad = 8'($urandom_range(0, 255));
		it.shade = 4'($urandom_range(0, 15));
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			it.op = nfb_pkg::CMD_READ;
			if ($urandom_range(0, 9) < 7) begin
				it.xs = clamp8(int'(mark_x) + int'($urandom_range(0, 6)) - 3);
				it.ys = clamp8(int'(mark_y) + int'($urandom_range(0, 6)) - 3);
			end
		end else if (sel < 40) begin
			it.op = nfb_pkg::CMD_PIXEL;
		end else if (sel < 50) begin
			it.op = nfb_pkg::CMD_HLINE;
			it.xe = span_end(it.xs, 20, 1'b1);
		end else if (sel < 60) begin
			it.op = nfb_pkg::CMD_VLINE;
			it.ye = span_end(it.ys, 20, 1'b1);
		end else if (sel < 70) begin
			it.op = nfb_pkg::CMD_RECT;
			it.xe = span_end(it.xs, 16, 1'b1);
			it.ye = span_end(it.ys, 16, 1'b1);
		end else if (sel < 80) begin
			it.op = nfb_pkg::CMD_FILL;
			if (big_fills < MAX_BIG_FILLS && $urandom_range(0, 99) == 0) begin
				big_fills++;
			end else begin
				it.xe = span_end(it.xs, 7, 1'b0);
				it.ye = span_end(it.ys, 7, 1'b0);
			end
		end else if (sel < 95) begin
			it.op = nfb_pkg::CMD_CIRCLE;
			if ($urandom_range(0, 9) != 0)
				it.rad = 8'($urandom_range(0, 24));
		end else begin
			it.op = CMD_NONE;
		end
		if (it.op != nfb_pkg::CMD_READ && it.op != CMD_NONE) begin
			mark_x = it.xs;
			mark_y = (it.op == nfb_pkg::CMD_CIRCLE) ? clamp8(int'(it.ys) + int'(it.rad))
			                                        : it.ys;
		end
	endtask

	// Called just after a falling edge; returns just after the falling edge that follows
	// the transfer.
	task automatic issue(input draw_item_t it);
		int gap;
		if (burst_left == 0) begin
			start = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		start = 1'b1;
		cmd = it.op;
		x_start = it.xs;
		y_start = it.ys;
		x_end = it.xe;
		y_end = it.ye;
		radius = it.rad;
		shade = it.shade;
		pin_valid = it.pinned;
		pin_value = it.pin_value;
		pin_in = it.pin_in;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (pending_reads.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		draw_item_t it;
		int issued;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = nfb_pkg::CMD_PIXEL;
		x_start = 8'd0;
		y_start = 8'd0;
		x_end = 8'd0;
		y_end = 8'd0;
		radius = 8'd0;
		shade = 4'd0;
		pin_valid = 1'b0;
		pin_value = 4'd0;
		pin_in = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[i])
			issue(DIRECTED_ROWS[i]);
		wait_drained();

		issued = 0;
		while (issued < NUM_RANDOM) begin
			pick_random(it);
			if ($urandom_range(0, 49) == 0)
				wait_drained();
			issue(it);
			if (it.op != CMD_NONE)
				issued++;
		end

		start = 1'b0;
		while (busy)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (pending_reads.size() != 0) begin
			$error("%0d readback transfers never arrived", pending_reads.size());
			errors++;
		end

		$display("Covered %0d draw commands (%0d whole-frame-scale fills), %0d reads,",
			n_draws, big_fills, n_reads);
		$display("%0d unused codes; readbacks compared: %0d; errors found: %0d.",
			n_unused, n_checked, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
